@@ design/isr64_pkg.sv @@
// Shared constants and types for the 64-bit integer square root block.
// Used by the controller, the datapath and the top level; no dependencies.
package isr64_pkg;

  localparam int RADICAND_BITS_DEF = 64;
  localparam int RADICAND_PORT_BITS = 64;
  localparam int ROOT_BITS = 32;

  typedef struct packed {
    logic load;
    logic step;
  } isr64_cmd_t;

endpackage

@@ design/isr64_ctrl.sv @@
// Controller state machine for the integer square root block.
// Counts the root-bit iterations and issues load and step commands; uses isr64_pkg.
module isr64_ctrl #(
  parameter int RADICAND_BITS = isr64_pkg::RADICAND_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output isr64_pkg::isr64_cmd_t cmd
);

  localparam int STEPS = (RADICAND_BITS + 1) / 2;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = CNT_LAST;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy      = (state_r == ST_RUN);
  assign out_valid = done_r;

endmodule

@@ design/isr64_dp.sv @@
// Datapath of the integer square root block: remainder, partial root and trial bit.
// One restoring step per step command; uses isr64_pkg.
module isr64_dp #(
  parameter int RADICAND_BITS = isr64_pkg::RADICAND_BITS_DEF
) (
  input  logic                                   clk,
  input  isr64_pkg::isr64_cmd_t                  cmd,
  input  logic [isr64_pkg::RADICAND_PORT_BITS-1:0] radicand,
  output logic [isr64_pkg::ROOT_BITS-1:0]        root
);

  localparam int RB  = RADICAND_BITS;
  localparam int TOP = ((RB - 1) / 2) * 2;
  localparam logic [RB-1:0] TRIAL_INIT = RB'(1) << TOP;

  logic [RB-1:0] rem_r, rem_nxt;
  logic [RB-1:0] acc_r, acc_nxt;
  logic [RB-1:0] trial_r, trial_nxt;
  logic [RB:0]   cand;
  logic          fits;

  assign cand = {1'b0, acc_r} + {1'b0, trial_r};
  assign fits = ({1'b0, rem_r} >= cand);

  always_comb begin
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    trial_nxt = trial_r;
    if (cmd.load) begin
      rem_nxt   = radicand[RB-1:0];
      acc_nxt   = '0;
      trial_nxt = TRIAL_INIT;
    end else if (cmd.step) begin
      trial_nxt = trial_r >> 2;
      if (fits) begin
        rem_nxt = rem_r - cand[RB-1:0];
        acc_nxt = (acc_r >> 1) + trial_r;
      end else begin
        acc_nxt = acc_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    acc_r   <= acc_nxt;
    trial_r <= trial_nxt;
  end

  assign root = isr64_pkg::ROOT_BITS'(acc_r);

endmodule

@@ design/integer_square_root_64.sv @@
// Integer square root, 64-bit radicand to 32-bit floor root, restoring method.
// One root bit is resolved per cycle by the datapath; busy is high while iterating, and start
// is ignored while busy, so a new radicand is taken only once the previous root is done.
// Reset (synchronous, active low) returns the controller to idle with no result pending.
// The result is shown for one cycle on out_valid and cannot be stalled by the receiver.
module integer_square_root_64 #(
  parameter int RADICAND_BITS = isr64_pkg::RADICAND_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [isr64_pkg::RADICAND_PORT_BITS-1:0] in_radicand,
  output logic                                     out_valid,
  output logic [isr64_pkg::ROOT_BITS-1:0]          out_root
);

  isr64_pkg::isr64_cmd_t cmd;

  isr64_ctrl #(
    .RADICAND_BITS(RADICAND_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  isr64_dp #(
    .RADICAND_BITS(RADICAND_BITS)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .radicand(in_radicand),
    .root    (out_root)
  );

endmodule
